@@ design/utv_pkg.sv @@
`timescale 1ns / 1ps

package utv_pkg;

    localparam logic [7:0]  CtrlLimit   = 8'h20;
    localparam logic [7:0]  DelChar     = 8'h7f;
    localparam logic [7:0]  AsciiLimit  = 8'h80;
    localparam logic [7:0]  Lead2Low    = 8'hc2;
    localparam logic [7:0]  Lead2High   = 8'hdf;
    localparam logic [7:0]  Lead3Low    = 8'he0;
    localparam logic [7:0]  Lead3High   = 8'hef;
    localparam logic [7:0]  Lead4Low    = 8'hf0;
    localparam logic [7:0]  Lead4High   = 8'hf4;
    localparam logic [1:0]  ContMark    = 2'b10;
    localparam logic [20:0] Min3Byte    = 21'h000800;
    localparam logic [20:0] Min4Byte    = 21'h010000;
    localparam logic [20:0] MaxCode     = 21'h10ffff;
    localparam logic [20:0] SurrLow     = 21'h00d800;
    localparam logic [20:0] SurrHigh    = 21'h00dfff;
    localparam logic [8:0]  SatCount    = 9'd256;

    localparam logic [1:0]  SeqNone     = 2'd0;
    localparam logic [1:0]  SeqTwo      = 2'd1;
    localparam logic [1:0]  SeqThree    = 2'd2;
    localparam logic [1:0]  SeqFour     = 2'd3;

    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] codepoint;
        logic [1:0]  seq_class;
        logic [8:0]  seen_count;
        logic        failed;
    } utv_state_t;

    typedef struct packed {
        logic [8:0] byte_count;
        logic       is_valid;
    } utv_result_t;

endpackage

@@ design/utv_step.sv @@
`timescale 1ns / 1ps

module utv_step (
    input  utv_pkg::utv_state_t  state,
    input  logic [7:0]           data_byte,
    input  logic                 has_byte,
    input  logic                 last_item,
    input  logic [7:0]           max_length,
    output utv_pkg::utv_state_t  state_next,
    output utv_pkg::utv_result_t result
);
    import utv_pkg::*;

    always_comb
    begin
        utv_state_t  s;
        logic [20:0] cp_new;
        s      = state;
        cp_new = {state.codepoint[14:0], data_byte[5:0]};
        if (has_byte)
        begin
            if (s.seen_count != SatCount)
                s.seen_count = s.seen_count + 9'd1;
            if (!s.failed)
            begin
                if (s.pending == 2'd0)
                begin
                    if (data_byte < AsciiLimit)
                    begin
                        if (data_byte < CtrlLimit || data_byte == DelChar)
                            s.failed = 1'b1;
                    end
                    else if (data_byte >= Lead2Low && data_byte <= Lead2High)
                    begin
                        s.codepoint = {16'd0, data_byte[4:0]};
                        s.pending   = 2'd1;
                        s.seq_class = SeqTwo;
                    end
                    else if (data_byte >= Lead3Low && data_byte <= Lead3High)
                    begin
                        s.codepoint = {17'd0, data_byte[3:0]};
                        s.pending   = 2'd2;
                        s.seq_class = SeqThree;
                    end
                    else if (data_byte >= Lead4Low && data_byte <= Lead4High)
                    begin
                        s.codepoint = {18'd0, data_byte[2:0]};
                        s.pending   = 2'd3;
                        s.seq_class = SeqFour;
                    end
                    else
                    begin
                        s.failed = 1'b1;
                    end
                end
                else if (data_byte[7:6] != ContMark)
                begin
                    s.failed = 1'b1;
                end
                else
                begin
                    s.pending = s.pending - 2'd1;
                    if (s.pending == 2'd0)
                    begin
                        if ((s.seq_class == SeqThree && cp_new < Min3Byte) ||
                            (s.seq_class == SeqFour && cp_new < Min4Byte) ||
                            cp_new > MaxCode ||
                            (cp_new >= SurrLow && cp_new <= SurrHigh))
                            s.failed = 1'b1;
                        s.seq_class = SeqNone;
                        s.codepoint = '0;
                    end
                    else
                    begin
                        s.codepoint = cp_new;
                    end
                end
            end
        end
        result.is_valid   = !s.failed && s.pending == 2'd0 && s.seen_count != 9'd0 &&
                            s.seen_count <= {1'b0, max_length};
        result.byte_count = s.seen_count;
        state_next        = last_item ? '0 : s;
    end

endmodule

@@ design/utf8_text_validator_unit.sv @@
`timescale 1ns / 1ps

// strict utf-8 checker for byte strings: one byte per beat on the slave side, tuser set
// when tdata carries a byte, tlast closing the string. the block takes one beat every
// cycle unless stalled; each beat is held in the input register and decoded out of it,
// updating the string state, and the beat with tlast leaves one result (pass bit and
// byte count, saturating at 256) in the output register, which follows the input register.
// the decoder state register closing on itself sets that one-beat-per-cycle rate; only a
// closing beat waiting behind an untaken result stalls the input.
// max_length may be written only while no string result is outstanding.
module utf8_text_validator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,        // max_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // data_byte
    input  logic        s_axis_tuser,    // has_byte
    input  logic        s_axis_tlast,    // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // zero pad, byte_count[8:0], is_valid at bit 0
);
    import utv_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_has_reg;
    logic        in_last_reg;
    logic [7:0]  max_len_reg;
    logic        out_valid_reg;
    utv_result_t out_data_reg;
    utv_state_t  state_reg;
    utv_state_t  state_next;
    utv_result_t result_next;
    logic        advance;
    logic        s_accept;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && !(in_last_reg && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

    utv_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .has_byte   (in_has_reg),
        .last_item  (in_last_reg),
        .max_length (max_len_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= 8'd48;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
                max_len_reg <= cfg_data;
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_has_reg  <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg)
            out_data_reg <= result_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending != 2'd0 |->
            state_reg.seq_class != SeqNone && state_reg.pending <= state_reg.seq_class)
        else $error("pending continuations exceed open sequence length");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.seq_class == SeqNone |-> state_reg.codepoint == 21'd0)
        else $error("partial code point left outside a sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.is_valid |->
            out_data_reg.byte_count != 9'd0 && out_data_reg.byte_count < SatCount)
        else $error("passing string with impossible byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready |=>
            in_valid_reg && $stable(state_reg))
        else $error("closing beat dropped while result stalled");

endmodule
